### design/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RNPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RNPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rnpp_pkg.sv
// Package: types, encodings and widths for the next-PC predictor.
package rnpp_pkg;

    localparam int XLEN_DEFAULT = 64;
    localparam int WORD_W       = 64;
    localparam int INSTR_W      = 32;
    localparam int IMM_W        = 21;

    // Major opcodes of full-width instructions
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;

    // Compressed quadrants
    localparam logic [1:0] QUAD_C1   = 2'b01;
    localparam logic [1:0] QUAD_C2   = 2'b10;
    localparam logic [1:0] QUAD_FULL = 2'b11;

    // Compressed funct3 codes
    localparam logic [2:0] CF3_JAL  = 3'd1;
    localparam logic [2:0] CF3_JR   = 3'd4;
    localparam logic [2:0] CF3_J    = 3'd5;
    localparam logic [2:0] CF3_BEQZ = 3'd6;
    localparam logic [2:0] CF3_BNEZ = 3'd7;

    // Branch funct3 codes
    localparam logic [2:0] BF3_BEQ  = 3'd0;
    localparam logic [2:0] BF3_BNE  = 3'd1;
    localparam logic [2:0] BF3_BLT  = 3'd4;
    localparam logic [2:0] BF3_BGE  = 3'd5;
    localparam logic [2:0] BF3_BLTU = 3'd6;
    localparam logic [2:0] BF3_BGEU = 3'd7;

    // Redirect condition evaluated in the compare stage
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_EQ,
        COND_NE,
        COND_LT,
        COND_GE,
        COND_LTU,
        COND_GEU
    } cond_t;

    // Decoded control for one word
    typedef struct packed {
        cond_t cond;
        logic  base_rs1;   // target base is rs1 instead of pc
        logic  clr_bit0;   // register jumps clear target bit 0
        logic  compressed; // fall-through is pc+2
        logic  b_zero;     // compare rs1 against zero
    } ctrl_t;

endpackage

### design/riscv_next_pc_predictor.sv
// Three-stage pipeline that resolves the next PC of one instruction word per
// cycle: decode, then compare and add, then select into the output register.
// A word accepted into stage 1 passes through stage 2 into the output
// registers and shows on result_valid until the receiver takes it; one word
// per cycle is sustained while result_stall stays low. Each stage holds its
// word while the next one is full and stalled, so item_stall follows
// result_stall combinationally only once all three stages are occupied.
// Addresses are XLEN bits wide and zero-extended on next_pc.
module riscv_next_pc_predictor #(
    parameter int XLEN = rnpp_pkg::XLEN_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [rnpp_pkg::WORD_W-1:0]   pc,
    input  logic [rnpp_pkg::INSTR_W-1:0]  instr_word,
    input  logic [rnpp_pkg::WORD_W-1:0]   rs1_value,
    input  logic [rnpp_pkg::WORD_W-1:0]   rs2_value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [rnpp_pkg::WORD_W-1:0]   next_pc,
    output logic                          redirected
);

    rnpp_pkg::ctrl_t dec_ctrl;
    logic [XLEN-1:0] dec_imm;

    // Stage 1 registers
    logic            s1_valid_reg;
    rnpp_pkg::ctrl_t s1_ctrl_reg;
    logic [XLEN-1:0] s1_imm_reg;
    logic [XLEN-1:0] s1_pc_reg;
    logic [XLEN-1:0] s1_a_reg;
    logic [XLEN-1:0] s1_b_reg;

    // Stage 2 registers
    logic            s2_valid_reg;
    logic            s2_take_reg;
    logic [XLEN-1:0] s2_target_reg;
    logic [XLEN-1:0] s2_seq_reg;

    // Stage 3 (output) registers
    logic            s3_valid_reg;
    logic            s3_redir_reg;
    logic [XLEN-1:0] s3_next_pc_reg;

    logic            s1_ready;
    logic            s2_ready;
    logic            s3_ready;

    logic            s2_take_next;
    logic [XLEN-1:0] s2_target_next;
    logic [XLEN-1:0] s2_seq_next;
    logic [XLEN-1:0] s2_base;
    logic [XLEN-1:0] s3_next_pc_next;

    rnpp_decode #(
        .XLEN (XLEN)
    ) u_decode (
        .instr_word (instr_word),
        .ctrl       (dec_ctrl),
        .imm        (dec_imm)
    );

    // Flow control: a stage loads when empty or when its word moves on
    assign s3_ready   = !s3_valid_reg || !result_stall;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign item_stall = !s1_ready;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= item_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1: decoded word and operands
    always_ff @(posedge clk)
    begin
        if (s1_ready && item_valid)
        begin
            s1_ctrl_reg <= dec_ctrl;
            s1_imm_reg  <= dec_imm;
            s1_pc_reg   <= pc[XLEN-1:0];
            s1_a_reg    <= rs1_value[XLEN-1:0];
            s1_b_reg    <= dec_ctrl.b_zero ? '0 : rs2_value[XLEN-1:0];
        end
    end

    // Stage 2: condition, target and fall-through adds
    assign s2_base        = s1_ctrl_reg.base_rs1 ? s1_a_reg : s1_pc_reg;
    assign s2_target_next = (s2_base + s1_imm_reg) &
                            ~XLEN'(s1_ctrl_reg.clr_bit0);
    assign s2_seq_next    = s1_pc_reg + (s1_ctrl_reg.compressed ? XLEN'(2) : XLEN'(4));

    always_comb
    begin
        unique case (s1_ctrl_reg.cond)
            rnpp_pkg::COND_NEVER:  s2_take_next = 1'b0;
            rnpp_pkg::COND_ALWAYS: s2_take_next = 1'b1;
            rnpp_pkg::COND_EQ:     s2_take_next = (s1_a_reg == s1_b_reg);
            rnpp_pkg::COND_NE:     s2_take_next = (s1_a_reg != s1_b_reg);
            rnpp_pkg::COND_LT:     s2_take_next = ($signed(s1_a_reg) < $signed(s1_b_reg));
            rnpp_pkg::COND_GE:     s2_take_next = ($signed(s1_a_reg) >= $signed(s1_b_reg));
            rnpp_pkg::COND_LTU:    s2_take_next = (s1_a_reg < s1_b_reg);
            rnpp_pkg::COND_GEU:    s2_take_next = (s1_a_reg >= s1_b_reg);
            default:               s2_take_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_take_reg   <= s2_take_next;
            s2_target_reg <= s2_target_next;
            s2_seq_reg    <= s2_seq_next;
        end
    end

    // Stage 3: pick the target or the fall-through address
    assign s3_next_pc_next = s2_take_reg ? s2_target_reg : s2_seq_reg;

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_next_pc_reg <= s3_next_pc_next;
            s3_redir_reg   <= s2_take_reg;
        end
    end

    assign result_valid = s3_valid_reg;
    assign redirected   = s3_redir_reg;
    assign next_pc      = rnpp_pkg::WORD_W'(s3_next_pc_reg);

endmodule

### design/rnpp_decode.sv
// Instruction decode: redirect condition, target base and sign-extended offset.
module rnpp_decode #(
    parameter int XLEN = rnpp_pkg::XLEN_DEFAULT
) (
    input  logic [rnpp_pkg::INSTR_W-1:0] instr_word,
    output rnpp_pkg::ctrl_t              ctrl,
    output logic [XLEN-1:0]              imm
);

    logic [15:0]                       c;
    logic [rnpp_pkg::INSTR_W-1:0]      w;
    logic [11:0]                       off_cj;
    logic [8:0]                        off_cb;
    logic [20:0]                       off_j;
    logic [12:0]                       off_b;
    logic [11:0]                       off_i;
    logic signed [rnpp_pkg::IMM_W-1:0] imm_s;

    assign w = instr_word;
    assign c = instr_word[15:0];

    // Offset fields, scrambled as the encodings place them
    assign off_cj = {c[12], c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
    assign off_cb = {c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
    assign off_j  = {w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign off_b  = {w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign off_i  = w[31:20];

    // Classify the word
    always_comb
    begin
        ctrl.cond       = rnpp_pkg::COND_NEVER;
        ctrl.base_rs1   = 1'b0;
        ctrl.clr_bit0   = 1'b0;
        ctrl.compressed = (w[1:0] != rnpp_pkg::QUAD_FULL);
        ctrl.b_zero     = 1'b0;
        imm_s           = '0;
        if (w[1:0] != rnpp_pkg::QUAD_FULL)
        begin
            if (c[1:0] == rnpp_pkg::QUAD_C1 && (c[15:13] == rnpp_pkg::CF3_J ||
                (c[15:13] == rnpp_pkg::CF3_JAL && XLEN == 32)))
            begin
                ctrl.cond = rnpp_pkg::COND_ALWAYS;
                imm_s     = rnpp_pkg::IMM_W'($signed(off_cj));
            end
            else if (c[1:0] == rnpp_pkg::QUAD_C1 &&
                     (c[15:13] == rnpp_pkg::CF3_BEQZ || c[15:13] == rnpp_pkg::CF3_BNEZ))
            begin
                ctrl.cond   = (c[15:13] == rnpp_pkg::CF3_BEQZ) ? rnpp_pkg::COND_EQ
                                                                : rnpp_pkg::COND_NE;
                ctrl.b_zero = 1'b1;
                imm_s       = rnpp_pkg::IMM_W'($signed(off_cb));
            end
            else if (c[1:0] == rnpp_pkg::QUAD_C2 && c[15:13] == rnpp_pkg::CF3_JR &&
                     c[6:2] == 5'd0 && c[11:7] != 5'd0)
            begin
                // C.JR / C.JALR; rs1 of zero is reserved or C.EBREAK
                ctrl.cond     = rnpp_pkg::COND_ALWAYS;
                ctrl.base_rs1 = 1'b1;
                ctrl.clr_bit0 = 1'b1;
            end
        end
        else if (w[6:0] == rnpp_pkg::OPC_JAL)
        begin
            ctrl.cond = rnpp_pkg::COND_ALWAYS;
            imm_s     = $signed(off_j);
        end
        else if (w[6:0] == rnpp_pkg::OPC_JALR)
        begin
            ctrl.cond     = rnpp_pkg::COND_ALWAYS;
            ctrl.base_rs1 = 1'b1;
            ctrl.clr_bit0 = 1'b1;
            imm_s         = rnpp_pkg::IMM_W'($signed(off_i));
        end
        else if (w[6:0] == rnpp_pkg::OPC_BRANCH)
        begin
            imm_s = rnpp_pkg::IMM_W'($signed(off_b));
            unique case (w[14:12])
                rnpp_pkg::BF3_BEQ:  ctrl.cond = rnpp_pkg::COND_EQ;
                rnpp_pkg::BF3_BNE:  ctrl.cond = rnpp_pkg::COND_NE;
                rnpp_pkg::BF3_BLT:  ctrl.cond = rnpp_pkg::COND_LT;
                rnpp_pkg::BF3_BGE:  ctrl.cond = rnpp_pkg::COND_GE;
                rnpp_pkg::BF3_BLTU: ctrl.cond = rnpp_pkg::COND_LTU;
                rnpp_pkg::BF3_BGEU: ctrl.cond = rnpp_pkg::COND_GEU;
                default:            ctrl.cond = rnpp_pkg::COND_NEVER;
            endcase
        end
    end

    // Sign-extend the offset to the address width
    assign imm = XLEN'(imm_s);

endmodule

### design/rnpp_checker.sv
// Port-level checker for the next-PC predictor, bound to the top level.
`include "assert_macros.svh"

module rnpp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_stall,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [rnpp_pkg::WORD_W-1:0]   next_pc,
    input logic                          redirected
);

    logic                        out_hold;
    logic [rnpp_pkg::WORD_W:0]   out_word;

    assign out_hold = result_valid && result_stall;
    assign out_word = {next_pc, redirected};

    // Accepted word, then no output backpressure while it moves through stages 2 and 3
    sequence s_clear_path;
        (item_valid && !item_stall) ##1 !result_stall ##1 !result_stall;
    endsequence

    // A stalled result word stays offered
    `RNPP_ASSERT_NEXT(a_result_hold, clk, rst_n, out_hold, result_valid, "result word dropped")

    // A stalled result word keeps its value
    `RNPP_ASSERT_NEXT(a_result_stable, clk, rst_n, out_hold, $stable(out_word), "word changed")

    // Input backpressure only arises from a full pipe held at the output
    `RNPP_ASSERT_NOW(a_stall_source, clk, rst_n, item_stall, out_hold, "input stall unexplained")

    // An accepted word that meets no output stall moves on through the stages to the output
    `RNPP_ASSERT_NEXT(a_latency, clk, rst_n, s_clear_path, result_valid, "word arrived late")

endmodule

bind riscv_next_pc_predictor rnpp_checker u_rnpp_checker (.*);

### tb/sv/tb_top.sv
// Self-checking testbench for the next-PC resolver: directed, pressure and random words.
module tb_top;

    localparam int XLEN = rnpp_pkg::XLEN_DEFAULT;

    // Branch funct3 codes that are not defined
    localparam logic [2:0] BF3_RSVD2 = 3'd2;
    localparam logic [2:0] BF3_RSVD3 = 3'd3;

    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_TICKS = 10;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [rnpp_pkg::WORD_W-1:0] next_pc;
        logic                        redirected;
    } npc_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          item_valid   = 1'b0;
    logic                          item_stall;
    logic [rnpp_pkg::WORD_W-1:0]   pc           = '0;
    logic [rnpp_pkg::INSTR_W-1:0]  instr_word   = '0;
    logic [rnpp_pkg::WORD_W-1:0]   rs1_value    = '0;
    logic [rnpp_pkg::WORD_W-1:0]   rs2_value    = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic [rnpp_pkg::WORD_W-1:0]   next_pc;
    logic                          redirected;

    npc_t expected_npc_q[$];
    int   fail_count     = 0;
    int   words_sent     = 0;
    int   results_seen   = 0;
    int   redirects_seen = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    bit   hold_req       = 1'b0;

    riscv_next_pc_predictor #(.XLEN(XLEN)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .pc          (pc),
        .instr_word  (instr_word),
        .rs1_value   (rs1_value),
        .rs2_value   (rs2_value),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .next_pc     (next_pc),
        .redirected  (redirected)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Safety net against a hung handshake
    initial
    begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Next-PC resolution of one word, low XLEN bits, zero-extended
    function automatic npc_t resolve_next_pc(input logic [rnpp_pkg::WORD_W-1:0] pc_in,
                                             input logic [rnpp_pkg::INSTR_W-1:0] w,
                                             input logic [rnpp_pkg::WORD_W-1:0] a_in,
                                             input logic [rnpp_pkg::WORD_W-1:0] b_in);
        logic [XLEN-1:0] p, a, b, nxt;
        logic [15:0]     c;
        logic [11:0]     cj_off;
        logic [8:0]      cb_off;
        logic [20:0]     j_off;
        logic [12:0]     b_off;
        logic            take;
        npc_t            res;
        p    = pc_in[XLEN-1:0];
        a    = a_in[XLEN-1:0];
        b    = b_in[XLEN-1:0];
        take = 1'b0;
        if (w[1:0] != rnpp_pkg::QUAD_FULL)
        begin
            c   = w[15:0];
            nxt = p + XLEN'(2);
            if (c[1:0] == rnpp_pkg::QUAD_C1 &&
                (c[15:13] == rnpp_pkg::CF3_J ||
                 (c[15:13] == rnpp_pkg::CF3_JAL && XLEN == 32)))
            begin
                cj_off = {c[12], c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3], 1'b0};
                nxt    = p + {{(XLEN-12){cj_off[11]}}, cj_off};
                take   = 1'b1;
            end
            else if (c[1:0] == rnpp_pkg::QUAD_C1 &&
                     (c[15:13] == rnpp_pkg::CF3_BEQZ || c[15:13] == rnpp_pkg::CF3_BNEZ))
            begin
                cb_off = {c[12], c[6:5], c[2], c[11:10], c[4:3], 1'b0};
                take   = (c[15:13] == rnpp_pkg::CF3_BEQZ) ? (a == '0) : (a != '0);
                if (take)
                    nxt = p + {{(XLEN-9){cb_off[8]}}, cb_off};
            end
            else if (c[1:0] == rnpp_pkg::QUAD_C2 && c[15:13] == rnpp_pkg::CF3_JR &&
                     c[6:2] == 5'd0 && c[11:7] != 5'd0)
            begin
                // register jump, rs2 field zero and rs1 nonzero
                nxt  = a & ~{{(XLEN-1){1'b0}}, 1'b1};
                take = 1'b1;
            end
        end
        else
        begin
            nxt = p + XLEN'(4);
            case (w[6:0])
                rnpp_pkg::OPC_JAL:
                begin
                    j_off = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                    nxt   = p + {{(XLEN-21){j_off[20]}}, j_off};
                    take  = 1'b1;
                end
                rnpp_pkg::OPC_JALR:
                begin
                    nxt  = (a + {{(XLEN-12){w[31]}}, w[31:20]}) &
                           ~{{(XLEN-1){1'b0}}, 1'b1};
                    take = 1'b1;
                end
                rnpp_pkg::OPC_BRANCH:
                begin
                    b_off = {w[31], w[7], w[30:25], w[11:8], 1'b0};
                    case (w[14:12])
                        rnpp_pkg::BF3_BEQ:  take = (a == b);
                        rnpp_pkg::BF3_BNE:  take = (a != b);
                        rnpp_pkg::BF3_BLT:  take = ($signed(a) < $signed(b));
                        rnpp_pkg::BF3_BGE:  take = ($signed(a) >= $signed(b));
                        rnpp_pkg::BF3_BLTU: take = (a < b);
                        rnpp_pkg::BF3_BGEU: take = (a >= b);
                        default:            take = 1'b0;
                    endcase
                    if (take)
                        nxt = p + {{(XLEN-13){b_off[12]}}, b_off};
                end
                default: ;
            endcase
        end
        res.next_pc    = rnpp_pkg::WORD_W'(nxt);
        res.redirected = take;
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endfunction

    // Receiver: random stall, or a long hold-off on request
    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Predict on each accepted word, check each accepted result; sampled mid-cycle
    always @(negedge clk)
    begin : check_results
        npc_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                expected_npc_q.push_back(resolve_next_pc(pc, instr_word, rs1_value,
                                                         rs2_value));
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (redirected)
                    redirects_seen++;
                if (expected_npc_q.size() == 0)
                begin
                    note_failure($sformatf("result with none pending: next_pc=%h redir=%b",
                                           next_pc, redirected));
                end
                else
                begin
                    want = expected_npc_q.pop_front();
                    if (next_pc !== want.next_pc)
                        note_failure($sformatf("next_pc: expected %h, got %h",
                                               want.next_pc, next_pc));
                    if (redirected !== want.redirected)
                        note_failure($sformatf("redirected: expected %b, got %b (next_pc %h)",
                                               want.redirected, redirected, want.next_pc));
                end
            end
        end
    end

    // Offer one word; returns at the edge where it is taken
    task automatic send_word(input logic [63:0] pc_in, input logic [31:0] w,
                             input logic [63:0] a, input logic [63:0] b);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        pc         <= pc_in;
        instr_word <= w;
        rs1_value  <= a;
        rs2_value  <= b;
        do
        begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
        end while (!taken);
        words_sent++;
    endtask

    task automatic do_reset();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // Extremes of the fields, each instruction kind and the corner encodings
    task automatic test_directed();
        logic [63:0] top;
        top = '1;
        // forward jump that wraps past the top of the address space
        send_word(top - 2, {1'b0, 10'h002, 1'b0, 8'h00, 5'd0, rnpp_pkg::OPC_JAL}, '0, '0);
        send_word(64'h0, {1'b1, 10'h3ff, 1'b1, 8'hff, 5'd0, rnpp_pkg::OPC_JAL}, top, top);
        send_word(64'h1000, {16'h0, rnpp_pkg::CF3_J, 11'h400, rnpp_pkg::QUAD_C1}, '0, '0);
        send_word(64'h1000, {16'hffff, rnpp_pkg::CF3_J, 11'h3ff, rnpp_pkg::QUAD_C1}, '0, '0);
        send_word(64'h2000, {16'h0, rnpp_pkg::CF3_JAL, 11'h155, rnpp_pkg::QUAD_C1}, '0, '0);
        send_word(64'h3000, {16'h0, rnpp_pkg::CF3_BEQZ, 3'b111, 3'd2, 5'h1f,
                             rnpp_pkg::QUAD_C1}, '0, '0);
        send_word(64'h3000, {16'h0, rnpp_pkg::CF3_BEQZ, 3'b100, 3'd2, 5'h00,
                             rnpp_pkg::QUAD_C1}, 64'h1, '0);
        send_word(64'h3000, {16'h0, rnpp_pkg::CF3_BNEZ, 3'b011, 3'd5, 5'h1f,
                             rnpp_pkg::QUAD_C1}, top, '0);
        send_word(64'h3000, {16'h0, rnpp_pkg::CF3_BNEZ, 3'b011, 3'd5, 5'h1f,
                             rnpp_pkg::QUAD_C1}, '0, '0);
        send_word(64'h4000, {16'h0, rnpp_pkg::CF3_JR, 1'b0, 5'd1, 5'd0, rnpp_pkg::QUAD_C2},
                  top, '0);
        send_word(64'h4000, {16'h0, rnpp_pkg::CF3_JR, 1'b1, 5'd31, 5'd0, rnpp_pkg::QUAD_C2},
                  64'h1235, '0);
        // reserved register jump and breakpoint: rs1 zero
        send_word(64'h4000, {16'h0, rnpp_pkg::CF3_JR, 1'b0, 5'd0, 5'd0, rnpp_pkg::QUAD_C2},
                  top, '0);
        send_word(64'h4000, {16'h0, rnpp_pkg::CF3_JR, 1'b1, 5'd0, 5'd0, rnpp_pkg::QUAD_C2},
                  top, '0);
        send_word(64'h5000, {12'hfff, 5'd1, 3'd0, 5'd1, rnpp_pkg::OPC_JALR}, 64'h0, '0);
        send_word(64'h5000, {12'h7ff, 5'd1, 3'd0, 5'd1, rnpp_pkg::OPC_JALR}, top, '0);
        // signed versus unsigned compares with sign bits differing
        send_word(64'h6000, {1'b1, 6'h3f, 5'd2, 5'd1, rnpp_pkg::BF3_BLT, 4'hf, 1'b1,
                             rnpp_pkg::OPC_BRANCH}, 64'h8000_0000_0000_0000, 64'h1);
        send_word(64'h6000, {1'b0, 6'h00, 5'd2, 5'd1, rnpp_pkg::BF3_BGE, 4'h1, 1'b0,
                             rnpp_pkg::OPC_BRANCH}, 64'h8000_0000_0000_0000, 64'h1);
        send_word(64'h6000, {1'b0, 6'h01, 5'd2, 5'd1, rnpp_pkg::BF3_BLTU, 4'h2, 1'b0,
                             rnpp_pkg::OPC_BRANCH}, 64'h8000_0000_0000_0000, 64'h1);
        send_word(64'h6000, {1'b1, 6'h00, 5'd2, 5'd1, rnpp_pkg::BF3_BGEU, 4'h0, 1'b0,
                             rnpp_pkg::OPC_BRANCH}, 64'h8000_0000_0000_0000, 64'h1);
        send_word(64'h6000, {1'b0, 6'h10, 5'd2, 5'd1, rnpp_pkg::BF3_BEQ, 4'h4, 1'b0,
                             rnpp_pkg::OPC_BRANCH}, top, top);
        send_word(64'h6000, {1'b0, 6'h10, 5'd2, 5'd1, rnpp_pkg::BF3_BNE, 4'h4, 1'b0,
                             rnpp_pkg::OPC_BRANCH}, top, top);
        send_word(64'h6000, {1'b0, 6'h10, 5'd2, 5'd1, BF3_RSVD2, 4'h4, 1'b0,
                             rnpp_pkg::OPC_BRANCH}, 64'h1, 64'h2);
        send_word(64'h6000, {1'b0, 6'h10, 5'd2, 5'd1, BF3_RSVD3, 4'h4, 1'b0,
                             rnpp_pkg::OPC_BRANCH}, 64'h1, 64'h2);
        send_word(top, 32'h0000_0000, top, top);
        send_word(top - 3, 32'hffff_ffff, top, top);
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        for (i = 0; i < 40; i++)
            send_word(rand64(), {16'($urandom),
                                 $urandom_range(1) ? rnpp_pkg::CF3_BNEZ : rnpp_pkg::CF3_J,
                                 11'($urandom), rnpp_pkg::QUAD_C1}, rand64(), rand64());
    endtask

    // Mostly well-formed control-flow words with random content, some noise
    task automatic test_random(input int count);
        int           i;
        logic [63:0]  p, a, b;
        logic [31:0]  w;
        for (i = 0; i < count; i++)
        begin
            w = $urandom;
            a = rand64();
            b = rand64();
            case ($urandom_range(3))
                0:       p = '1 - 64'($urandom_range(63));
                1:       p = 64'($urandom_range(255));
                default: p = rand64();
            endcase
            case ($urandom_range(15))
                0:
                begin
                    w[15:13] = rnpp_pkg::CF3_J;
                    w[1:0]   = rnpp_pkg::QUAD_C1;
                end
                1:
                begin
                    w[15:13] = rnpp_pkg::CF3_JAL;
                    w[1:0]   = rnpp_pkg::QUAD_C1;
                end
                2, 3:
                begin
                    w[15:13] = $urandom_range(1) ? rnpp_pkg::CF3_BEQZ : rnpp_pkg::CF3_BNEZ;
                    w[1:0]   = rnpp_pkg::QUAD_C1;
                    if ($urandom_range(1))
                        a = '0;
                end
                4, 5:
                begin
                    w[15:13] = rnpp_pkg::CF3_JR;
                    w[1:0]   = rnpp_pkg::QUAD_C2;
                    if ($urandom_range(7) != 0)
                        w[6:2] = 5'd0;
                    if ($urandom_range(7) == 0)
                        w[11:7] = 5'd0;
                end
                6, 7:
                    w[6:0] = rnpp_pkg::OPC_JAL;
                8, 9:
                    w[6:0] = rnpp_pkg::OPC_JALR;
                10, 11, 12, 13:
                begin
                    w[6:0] = rnpp_pkg::OPC_BRANCH;
                    case ($urandom_range(3))
                        0: b = a;
                        1: b = a ^ 64'h8000_0000_0000_0000;
                        default: ;
                    endcase
                end
                14:
                    if (w[1:0] == rnpp_pkg::QUAD_FULL)
                        w[1:0] = rnpp_pkg::QUAD_C2;
                default:
                    w[1:0] = rnpp_pkg::QUAD_FULL;
            endcase
            send_word(p, w, a, b);
        end
    endtask

    initial
    begin : main_seq
        int waited;
        do_reset();
        send_idle_pct  = 31;
        recv_stall_pct = 76;
        test_directed();
        test_backpressure();
        send_idle_pct  = 31;
        recv_stall_pct = 76;
        test_random(300);
        send_idle_pct  = 76;
        recv_stall_pct = 31;
        test_random(300);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(185);
        item_valid <= 1'b0;

        // Drain what is still in flight
        waited = 0;
        while (expected_npc_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_TICKS) @(posedge clk);
        if (expected_npc_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_npc_q.size()));

        $display("Covered %0d words (directed, back-pressure, three idle mixes);",
                 words_sent);
        $display("checked %0d results, %0d redirects, %0d failures.",
                 results_seen, redirects_seen, fail_count);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
